FILE: hdl/glu_pkg.sv
// Package for the GCD/LCM unit: default data width and request codes.
// No dependencies; read first by the interfaces and the core.
package glu_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic {
    REQ_GCD = 1'b0,
    REQ_LCM = 1'b1
  } req_type_e;

endpackage

FILE: hdl/glu_if.sv
// Handshake interfaces of the GCD/LCM unit: request and response channels.
// Depends on glu_pkg for the default data width.
interface glu_req_if #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
);
  import glu_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface glu_rsp_if #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
);
  import glu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_value;
  logic                  overflow_flag;

  modport source (output valid, result_value, overflow_flag, input ready);
  modport sink   (input valid, result_value, overflow_flag, output ready);
endinterface

FILE: hdl/gcd_lcm_unit_core.sv
// GCD/LCM unit core: sequencer around one shared adder/subtractor.
// Depends on glu_pkg and the glu_req_if / glu_rsp_if interfaces.
//
// One item at a time. GCD runs Euclid's loop, each remainder taken by a
// restoring divider on the shared subtractor, plus one check state
// (ST_EUC_CHK) per step; up to about 46 steps at 32 bits. LCM adds one
// division (|a|/gcd) and one shift-add multiply on the same adder,
// saturating to 2^(DATA_WIDTH-1)-1 with overflow_flag set. The request
// side is ready only while idle; a finished result sits in an output
// register, so a new item is taken while the previous one waits on the
// response side.
module gcd_lcm_unit_core #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  glu_req_if.sink            req_i,
  glu_rsp_if.source          rsp_o
);
  import glu_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned AW  = W + 1;
  localparam int unsigned CW  = $clog2(W);
  localparam logic [CW-1:0]  CNT_LAST = CW'(W - 1);
  localparam logic [W-1:0]   LIMIT    = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EUC_CHK = 6'b000010,
    ST_EUC_DIV = 6'b000100,
    ST_QDIV    = 6'b001000,
    ST_MUL     = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic           req_q, req_d;
  logic [W-1:0]   ma_q, ma_d, mb_q, mb_d;
  logic [W-1:0]   x_q, x_d, y_q, y_d;
  logic [W-1:0]   rem_q, rem_d, dvd_q, dvd_d;
  logic [W-1:0]   acc_q, acc_d;
  logic           ovf_q, ovf_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]   fin_res_q, fin_res_d;
  logic           fin_ovf_q, fin_ovf_d;
  logic [W-1:0]   out_res_q;
  logic           out_ovf_q;
  logic           out_vld_q;

  logic [W-1:0]   mag_a, mag_b, divisor;
  logic [AW-1:0]  add_a, add_b, add_s;
  logic           add_cin, add_co;
  logic [AW-1:0]  rem_sh;
  logic           ge;
  logic [W-1:0]   rem_nxt;
  logic           out_load;
  logic           req_fire;

  assign mag_a = req_i.operand_a[W-1] ? W'(-req_i.operand_a) : W'(req_i.operand_a);
  assign mag_b = req_i.operand_b[W-1] ? W'(-req_i.operand_b) : W'(req_i.operand_b);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // shared adder: division steps subtract, multiply steps add
  assign divisor = (state_q == ST_QDIV) ? x_q : y_q;
  assign rem_sh  = {rem_q, dvd_q[W-1]};

  always_comb begin
    if (state_q == ST_MUL) begin
      add_a   = {acc_q, 1'b0};
      add_b   = dvd_q[W-1] ? {1'b0, mb_q} : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = rem_sh;
      add_b   = ~{1'b0, divisor};
      add_cin = 1'b1;
    end
  end

  assign {add_co, add_s} = {1'b0, add_a} + {1'b0, add_b} + {{AW{1'b0}}, add_cin};
  assign ge      = add_co;
  assign rem_nxt = ge ? add_s[W-1:0] : rem_sh[W-1:0];

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    ma_d      = ma_q;
    mb_d      = mb_q;
    x_d       = x_q;
    y_d       = y_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    fin_res_d = fin_res_q;
    fin_ovf_d = fin_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          req_d   = req_i.req_type;
          ma_d    = mag_a;
          mb_d    = mag_b;
          x_d     = mag_a;
          y_d     = mag_b;
          state_d = ST_EUC_CHK;
        end
      end
      ST_EUC_CHK: begin
        rem_d = '0;
        cnt_d = CNT_LAST;
        if (y_q == '0) begin
          fin_ovf_d = 1'b0;
          if (req_q == REQ_GCD) begin
            fin_res_d = x_q;
            state_d   = ST_DONE;
          end else if (ma_q == '0 || mb_q == '0) begin
            fin_res_d = '0;
            state_d   = ST_DONE;
          end else begin
            dvd_d   = ma_q;
            state_d = ST_QDIV;
          end
        end else begin
          dvd_d   = x_q;
          state_d = ST_EUC_DIV;
        end
      end
      ST_EUC_DIV: begin
        rem_d = rem_nxt;
        dvd_d = {dvd_q[W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          x_d     = y_q;
          y_d     = rem_nxt;
          state_d = ST_EUC_CHK;
        end
      end
      ST_QDIV: begin
        rem_d = rem_nxt;
        dvd_d = {dvd_q[W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          acc_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = CNT_LAST;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        dvd_d = {dvd_q[W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (!ovf_q) begin
          if (add_s[W] || add_s[W-1]) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = add_s[W-1:0];
          end
        end
        if (cnt_q == '0) begin
          fin_ovf_d = ovf_d;
          fin_res_d = ovf_d ? LIMIT : acc_d;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    x_q       <= x_d;
    y_q       <= y_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    acc_q     <= acc_d;
    ovf_q     <= ovf_d;
    cnt_q     <= cnt_d;
    fin_res_q <= fin_res_d;
    fin_ovf_q <= fin_ovf_d;
    if (out_load) begin
      out_res_q <= fin_res_q;
      out_ovf_q <= fin_ovf_q;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_value  = out_res_q;
  assign rsp_o.overflow_flag = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overflow_flag |-> rsp_o.result_value == LIMIT)
    else $error("overflow without saturated result");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EUC_DIV || state_q == ST_QDIV) |-> rem_q < divisor)
    else $error("partial remainder not below divisor");

  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL && !ovf_q |-> acc_q <= LIMIT)
    else $error("product accumulator above limit without overflow");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == ST_EUC_CHK)
    else $error("accepted item did not start Euclid loop");
`endif

endmodule

FILE: sim/gcd_lcm_unit_core_chk.sv
// Checker for the GCD/LCM unit: watches the request and response channels,
// predicts each result and compares it in order. Depends on glu_pkg and the
// glu_req_if / glu_rsp_if interfaces.
module gcd_lcm_unit_core_chk #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  glu_req_if          req_i,
  glu_rsp_if          rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned gcd_cnt_o,
  output int unsigned lcm_cnt_o,
  output int unsigned sat_cnt_o
);
  import glu_pkg::*;

  typedef struct packed {
    req_type_e             op;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] value;
    logic                  ovf;
  } outcome_t;

  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  outcome_t outcome_q[$];

  initial begin
    fail_cnt_o    = 0;
    pending_cnt_o = 0;
    gcd_cnt_o     = 0;
    lcm_cnt_o     = 0;
    sat_cnt_o     = 0;
  end

  function automatic logic [DATA_WIDTH-1:0] abs_word(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] euclid_gcd(input logic [DATA_WIDTH-1:0] x,
                                                      input logic [DATA_WIDTH-1:0] y);
    logic [DATA_WIDTH-1:0] r;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic outcome_t gcd_or_lcm(input req_type_e op,
                                          input logic [DATA_WIDTH-1:0] a,
                                          input logic [DATA_WIDTH-1:0] b);
    outcome_t                o;
    logic [DATA_WIDTH-1:0]   ma;
    logic [DATA_WIDTH-1:0]   mb;
    logic [DATA_WIDTH-1:0]   q;
    logic [2*DATA_WIDTH-1:0] prod;
    ma      = abs_word(a);
    mb      = abs_word(b);
    o.op    = op;
    o.a     = a;
    o.b     = b;
    o.ovf   = 1'b0;
    o.value = '0;
    if (op == REQ_GCD) begin
      o.value = euclid_gcd(ma, mb);
    end else if (ma != '0 && mb != '0) begin
      q = ma / euclid_gcd(ma, mb);
      if (q > SAT_MAX / mb) begin
        o.value = SAT_MAX;
        o.ovf   = 1'b1;
      end else begin
        prod = {{DATA_WIDTH{1'b0}}, q} * {{DATA_WIDTH{1'b0}}, mb};
        if (prod > {{DATA_WIDTH{1'b0}}, SAT_MAX}) begin
          o.value = SAT_MAX;
          o.ovf   = 1'b1;
        end else begin
          o.value = prod[DATA_WIDTH-1:0];
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item value %0h ovf %0b",
                                    rsp_i.result_value, rsp_i.overflow_flag));
        end else begin
          want = outcome_q.pop_front();
          if (rsp_i.result_value !== want.value)
            report_mismatch($sformatf("%s a %0h b %0h: value %0h, want %0h", want.op.name(),
                                      want.a, want.b, rsp_i.result_value, want.value));
          if (rsp_i.overflow_flag !== want.ovf)
            report_mismatch($sformatf("%s a %0h b %0h: overflow %0b, want %0b", want.op.name(),
                                      want.a, want.b, rsp_i.overflow_flag, want.ovf));
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = gcd_or_lcm(req_type_e'(req_i.req_type), req_i.operand_a, req_i.operand_b);
        outcome_q.push_back(want);
        if (want.op == REQ_GCD) gcd_cnt_o++;
        else lcm_cnt_o++;
        if (want.ovf) sat_cnt_o++;
      end
      pending_cnt_o = outcome_q.size();
    end
  end

endmodule

FILE: sim/gcd_lcm_unit_core_tb.sv
// Testbench top for the GCD/LCM unit: clock, reset, directed and random
// request items with random idling on both channels, and the verdict.
// Depends on glu_pkg, the channel interfaces, the core and its checker.
module gcd_lcm_unit_core_tb;
  import glu_pkg::*;

  localparam int unsigned W            = DATA_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned TAIL_CYCLES  = 1700;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  logic        clk_i;
  logic        rst_ni;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt, pending_cnt, gcd_cnt, lcm_cnt, sat_cnt;

  glu_req_if #(.DATA_WIDTH(W)) req_ch ();
  glu_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

  gcd_lcm_unit_core #(.DATA_WIDTH(W)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  gcd_lcm_unit_core_chk #(.DATA_WIDTH(W)) i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .gcd_cnt_o     (gcd_cnt),
    .lcm_cnt_o     (lcm_cnt),
    .sat_cnt_o     (sat_cnt)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // response-side stalls in bursts
  initial rsp_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 17);
    if (stall_left != 0) begin
      rsp_ch.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  function automatic logic [W-1:0] apply_sign(input logic [W-1:0] v);
    return $urandom_range(0, 1) ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] extreme_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return MAX_POS;
      4:       return MIN_NEG;
      default: return MIN_NEG + 1'b1;
    endcase
  endfunction

  task automatic pick_pair(output logic [W-1:0] a, output logic [W-1:0] b);
    logic [W-1:0] f0, f1, t;
    int unsigned  k, n;
    case ($urandom_range(0, 6))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        a = apply_sign($urandom_range(0, 1000));
        b = apply_sign($urandom_range(0, 1000));
      end
      2: begin
        k = $urandom_range(1, 5000);
        a = apply_sign(k * $urandom_range(0, 300));
        b = apply_sign(k * $urandom_range(0, 300));
      end
      3: begin
        // consecutive Fibonacci numbers: longest remainder chains
        f0 = 0;
        f1 = 1;
        n  = $urandom_range(10, 45);
        repeat (n) begin
          t  = f0 + f1;
          f0 = f1;
          f1 = t;
        end
        a = apply_sign(f1);
        b = apply_sign(f0);
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
      end
      4: begin
        a = apply_sign($urandom_range(20000, 70000));
        b = apply_sign($urandom_range(20000, 70000));
      end
      5: begin
        a = extreme_value();
        b = $urandom_range(0, 1) ? $urandom : apply_sign($urandom_range(0, 1000));
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
      end
      default: begin
        a = apply_sign(1 << $urandom_range(0, W - 1));
        b = apply_sign(1 << $urandom_range(0, W - 1));
      end
    endcase
  endtask

  // starts and ends at a falling edge; valid stays up for the caller
  task automatic send_item(input req_type_e op, input logic [W-1:0] a, input logic [W-1:0] b);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 17);
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.req_type  = op;
    req_ch.operand_a = a;
    req_ch.operand_b = b;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [W-1:0] a, b;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_GCD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(REQ_GCD, '0, '0);
    send_item(REQ_LCM, '0, '0);
    send_item(REQ_GCD, MIN_NEG, '0);
    send_item(REQ_GCD, '0, MIN_NEG);
    send_item(REQ_GCD, MIN_NEG, MIN_NEG);
    send_item(REQ_LCM, MIN_NEG, 1);
    send_item(REQ_LCM, MIN_NEG, MIN_NEG);
    send_item(REQ_LCM, 5, '0);
    send_item(REQ_LCM, '0, -7);
    send_item(REQ_GCD, MAX_POS, 1);
    send_item(REQ_GCD, -12, 18);
    send_item(REQ_LCM, -6, -4);
    send_item(REQ_LCM, MAX_POS, MAX_POS);
    send_item(REQ_LCM, MAX_POS, 1);
    send_item(REQ_LCM, MAX_POS, MAX_POS - 1'b1);
    send_item(REQ_GCD, 1836311903, 1134903170);
    send_item(REQ_GCD, -1134903170, 1836311903);
    send_item(REQ_LCM, 46341, 46340);
    send_item(REQ_LCM, 65536, 32769);
    send_item(REQ_LCM, '1, '1);
    send_item(REQ_GCD, '1, MIN_NEG);
    send_item(REQ_GCD, 32'h5555_5555, 32'hAAAA_AAAA);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
      if (i == HOLD_AT) begin
        req_ch.valid = 1'b0;
        while (pending_cnt != 0) @(negedge clk_i);
      end
      pick_pair(a, b);
      send_item($urandom_range(0, 1) ? REQ_LCM : REQ_GCD, a, b);
    end
    req_ch.valid = 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d gcd and %0d lcm items, %0d of them saturated,",
             gcd_cnt, lcm_cnt, sat_cnt);
    $display("with zero, sign and extreme operands and random stalls on both channels");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
